// ===== sv/seud_pkg.sv =====
// Shared types, character codes and helper functions for the string unescaper.
// Used by seud_ctrl, seud_dpath and string_escape_utf8_decoder. No dependencies.
`timescale 1ns / 1ps

package seud_pkg;

	// Decoder modes
	localparam logic [1:0] MODE_TEXT = 2'd0;
	localparam logic [1:0] MODE_ESC  = 2'd1;
	localparam logic [1:0] MODE_HEX  = 2'd2;
	localparam logic [1:0] MODE_LOOK = 2'd3;

	// Character codes
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ESC   = 8'h1B;

	// Surrogate prefixes (top six bits of a 16-bit code unit)
	localparam logic [5:0] SURR_HI = 6'b110110;
	localparam logic [5:0] SURR_LO = 6'b110111;

	// Depth of the held-byte store, replay queue and emission list
	localparam int HOLD_DEPTH = 6;

	// One result item
	typedef struct packed {
		logic       unterm;
		logic       done;
		logic       valid;
		logic [7:0] data;
	} res_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic work_left;
		logic stall;
	} stat_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} utf8_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] v;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok = 1'b1;
		r.v  = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.v = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r.v = c[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	// UTF-8 encoding of a code point up to U+10FFFF
	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t u;
		u.b = '0;
		if (cp < 21'h80) begin
			u.b[0] = cp[7:0];
			u.n    = 3'd1;
		end else if (cp < 21'h800) begin
			u.b[0] = {3'b110, cp[10:6]};
			u.b[1] = {2'b10, cp[5:0]};
			u.n    = 3'd2;
		end else if (cp <= 21'hFFFF) begin
			u.b[0] = {4'b1110, cp[15:12]};
			u.b[1] = {2'b10, cp[11:6]};
			u.b[2] = {2'b10, cp[5:0]};
			u.n    = 3'd3;
		end else begin
			u.b[0] = {5'b11110, cp[20:18]};
			u.b[1] = {2'b10, cp[17:12]};
			u.b[2] = {2'b10, cp[11:6]};
			u.b[3] = {2'b10, cp[5:0]};
			u.n    = 3'd4;
		end
		return u;
	endfunction

endpackage

// ===== sv/string_escape_utf8_decoder.sv =====
// Top level of the string-literal unescaper with UTF-8 output.
// Depends on seud_pkg, seud_ctrl and seud_dpath.
//
// Channel  Dir  Beat                 Contents
// s_*      in   one source byte      tdata: src_byte; tuser: end_of_source
// m_*      out  one decoded result   tdata: out_byte; tuser: flags; tlast: last of request
//
// A request is accepted, then runs its decode steps and a closing finish step
// that releases its last result. There is one step per source byte fed
// (replayed bytes included) and one per byte emitted from an escape expansion.
// Each result is held in a pending register until the next result or the end
// of the request is known. Reset clears all control state; m_tready low while
// the output register is full stalls the decode steps.
`timescale 1ns / 1ps

module string_escape_utf8_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] src_byte
	input  logic [0:0]  s_tuser,   // [0] end_of_source
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic [2:0]  m_tuser,   // [0] byte_valid, [1] string_done, [2] unterminated
	output logic        m_tlast
);

	seud_pkg::cmd_t  cmd;
	seud_pkg::stat_t stat;
	seud_pkg::res_t  res;

	seud_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	seud_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_byte   (s_tdata),
		.in_eos    (s_tuser[0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.out_last  (m_tlast)
	);

	assign m_tdata = res.data;
	assign m_tuser = {res.unterm, res.done, res.valid};

endmodule

// ===== sv/seud_ctrl.sv =====
// Controller: input handshake and sequencing of decode steps for one request.
// Depends on seud_pkg.
`timescale 1ns / 1ps

module seud_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  seud_pkg::stat_t stat,
	output seud_pkg::cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;

	// Command decode
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.step   = (state_q == ST_RUN) && !stat.stall && stat.work_left;
		cmd.finish = (state_q == ST_RUN) && !stat.stall && !stat.work_left;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (cmd.load) state_q <= ST_RUN;
				ST_RUN:  if (cmd.finish) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/seud_dpath.sv =====
// Datapath: decoder state, held bytes, replay queue, emission list and output stages.
// Depends on seud_pkg.
`timescale 1ns / 1ps

module seud_dpath (
	input  logic            clk,
	input  logic            arst_n,
	input  seud_pkg::cmd_t  cmd,
	output seud_pkg::stat_t stat,
	input  logic [7:0]      in_byte,
	input  logic            in_eos,
	output logic            out_valid,
	input  logic            out_ready,
	output seud_pkg::res_t  out_res,
	output logic            out_last
);

	localparam int D = seud_pkg::HOLD_DEPTH;

	// Decoder state
	logic [1:0]  mode_q, n_mode;
	logic [15:0] acc_q, n_acc;
	logic [15:0] hs_q, n_hs;
	logic [2:0]  hn_q, n_hn;
	logic [7:0]  held_q [D];
	logic [7:0]  n_held [D];
	// Replay queue
	logic [7:0]  fq_q [D];
	logic [7:0]  n_fq [D];
	logic [2:0]  fq_n_q, n_fq_n, fq_p_q, n_fq_p;
	logic        eos_q, n_eos;
	// Emission list
	logic [7:0]  em_q [D];
	logic [7:0]  n_em [D];
	logic [2:0]  em_n_q, n_em_n, em_p_q, n_em_p;
	// Pending result and output register
	logic           pend_v_q, out_v_q, out_last_q;
	seud_pkg::res_t pend_q, out_q;

	logic           push;
	seud_pkg::res_t push_r;
	logic [7:0]     b;
	seud_pkg::hex_t hx;
	logic [15:0]    acc_sh;
	logic           look_ok, out_free;
	seud_pkg::utf8_t u_hex, u_hs, u_pair;

	assign b      = fq_q[fq_p_q];
	assign hx     = seud_pkg::hex_decode(b);
	assign acc_sh = {acc_q[11:0], hx.v};
	assign u_hex  = seud_pkg::utf8_enc({5'd0, acc_sh});
	assign u_hs   = seud_pkg::utf8_enc({5'd0, hs_q});
	assign u_pair = seud_pkg::utf8_enc(21'h10000 + {1'b0, hs_q[9:0], acc_sh[9:0]});

	assign out_free       = !out_v_q || out_ready;
	assign stat.stall     = pend_v_q && !out_free;
	assign stat.work_left = (em_p_q != em_n_q) || (fq_p_q != fq_n_q) || eos_q;

	// Look-ahead match for the low-surrogate escape
	always_comb begin
		if (hn_q == 3'd0) begin
			look_ok = (b == seud_pkg::CH_BSL);
		end else if (hn_q == 3'd1) begin
			look_ok = (b == seud_pkg::CH_U);
		end else begin
			look_ok = hx.ok && (hn_q < 3'(D));
		end
	end

	// One decode step
	always_comb begin
		n_mode = mode_q;
		n_acc  = acc_q;
		n_hs   = hs_q;
		n_hn   = hn_q;
		n_held = held_q;
		n_fq   = fq_q;
		n_fq_n = fq_n_q;
		n_fq_p = fq_p_q;
		n_eos  = eos_q;
		n_em   = em_q;
		n_em_n = em_n_q;
		n_em_p = em_p_q;
		push   = 1'b0;
		push_r = '0;

		if (em_p_q != em_n_q) begin
			// drain emission list first
			push        = 1'b1;
			push_r.valid = 1'b1;
			push_r.data  = em_q[em_p_q];
			n_em_p      = em_p_q + 3'd1;
		end else if (fq_p_q != fq_n_q) begin
			unique case (mode_q)
				seud_pkg::MODE_ESC: begin
					n_fq_p = fq_p_q + 3'd1;
					n_mode = seud_pkg::MODE_TEXT;
					push_r.valid = 1'b1;
					push = 1'b1;
					case (b)
						seud_pkg::CH_QUOTE, seud_pkg::CH_BSL, seud_pkg::CH_SLASH:
							push_r.data = b;
						seud_pkg::CH_B: push_r.data = seud_pkg::CH_BS;
						seud_pkg::CH_F: push_r.data = seud_pkg::CH_FF;
						seud_pkg::CH_N: push_r.data = seud_pkg::CH_LF;
						seud_pkg::CH_R: push_r.data = seud_pkg::CH_CR;
						seud_pkg::CH_T: push_r.data = seud_pkg::CH_TAB;
						seud_pkg::CH_E: push_r.data = seud_pkg::CH_ESC;
						seud_pkg::CH_U: begin
							push   = 1'b0;
							n_mode = seud_pkg::MODE_HEX;
							n_acc  = '0;
							n_hn   = '0;
						end
						default: begin
							// unknown escape kept verbatim
							push    = 1'b0;
							n_em[0] = seud_pkg::CH_BSL;
							n_em[1] = b;
							n_em_n  = 3'd2;
							n_em_p  = 3'd0;
						end
					endcase
				end
				seud_pkg::MODE_HEX: begin
					if (!hx.ok) begin
						// malformed: backslash, u, held digits; byte handled again
						n_em[0] = seud_pkg::CH_BSL;
						n_em[1] = seud_pkg::CH_U;
						for (int i = 0; i < D - 2; i++) n_em[i+2] = held_q[i];
						n_em_n = hn_q + 3'd2;
						n_em_p = 3'd0;
						n_mode = seud_pkg::MODE_TEXT;
						n_acc  = '0;
						n_hn   = '0;
						n_hs   = '0;
					end else begin
						n_fq_p       = fq_p_q + 3'd1;
						n_held[hn_q] = b;
						if (hn_q == 3'd3) begin
							n_acc = '0;
							n_hn  = '0;
							n_hs  = '0;
							if (acc_sh[15:10] == seud_pkg::SURR_HI) begin
								n_hs   = acc_sh;
								n_mode = seud_pkg::MODE_LOOK;
							end else begin
								n_mode = seud_pkg::MODE_TEXT;
								for (int i = 0; i < 4; i++) n_em[i] = u_hex.b[i];
								n_em_n = u_hex.n;
								n_em_p = 3'd0;
							end
						end else begin
							n_acc = acc_sh;
							n_hn  = hn_q + 3'd1;
						end
					end
				end
				seud_pkg::MODE_LOOK: begin
					if (!look_ok || (hn_q == 3'd5 && acc_sh[15:10] != seud_pkg::SURR_LO)) begin
						// lone high surrogate, then replay held bytes and this byte
						for (int i = 0; i < 3; i++) n_em[i] = u_hs.b[i];
						n_em_n = 3'd3;
						n_em_p = 3'd0;
						for (int i = 0; i < D; i++) begin
							if (3'(i) < hn_q) n_fq[i] = held_q[i];
							else if (3'(i) == hn_q) n_fq[i] = b;
						end
						n_fq_n = hn_q + 3'd1;
						n_fq_p = 3'd0;
						n_mode = seud_pkg::MODE_TEXT;
						n_acc  = '0;
						n_hn   = '0;
						n_hs   = '0;
					end else if (hn_q < 3'd5) begin
						n_fq_p       = fq_p_q + 3'd1;
						n_held[hn_q] = b;
						n_hn         = hn_q + 3'd1;
						if (hn_q >= 3'd2) n_acc = acc_sh;
					end else begin
						// surrogate pair complete
						n_fq_p = fq_p_q + 3'd1;
						for (int i = 0; i < 4; i++) n_em[i] = u_pair.b[i];
						n_em_n = u_pair.n;
						n_em_p = 3'd0;
						n_mode = seud_pkg::MODE_TEXT;
						n_acc  = '0;
						n_hn   = '0;
						n_hs   = '0;
					end
				end
				default: begin
					n_fq_p = fq_p_q + 3'd1;
					if (b == seud_pkg::CH_QUOTE) begin
						push        = 1'b1;
						push_r.done = 1'b1;
						n_mode      = seud_pkg::MODE_TEXT;
						n_acc       = '0;
						n_hn        = '0;
						n_hs        = '0;
					end else if (b == seud_pkg::CH_LF) begin
						n_mode = seud_pkg::MODE_TEXT;
					end else if (b == seud_pkg::CH_BSL) begin
						n_mode = seud_pkg::MODE_ESC;
					end else begin
						push         = 1'b1;
						push_r.valid = 1'b1;
						push_r.data  = b;
					end
				end
			endcase
		end else begin
			// end of source: flush pending escape, then flag
			n_mode = seud_pkg::MODE_TEXT;
			n_acc  = '0;
			n_hn   = '0;
			n_hs   = '0;
			unique case (mode_q)
				seud_pkg::MODE_ESC: begin
					push         = 1'b1;
					push_r.valid = 1'b1;
					push_r.data  = seud_pkg::CH_BSL;
				end
				seud_pkg::MODE_HEX: begin
					n_em[0] = seud_pkg::CH_BSL;
					n_em[1] = seud_pkg::CH_U;
					for (int i = 0; i < D - 2; i++) n_em[i+2] = held_q[i];
					n_em_n = hn_q + 3'd2;
					n_em_p = 3'd0;
				end
				seud_pkg::MODE_LOOK: begin
					for (int i = 0; i < 3; i++) n_em[i] = u_hs.b[i];
					n_em_n = 3'd3;
					n_em_p = 3'd0;
					for (int i = 0; i < D; i++) begin
						if (3'(i) < hn_q) n_fq[i] = held_q[i];
					end
					n_fq_n = hn_q;
					n_fq_p = 3'd0;
				end
				default: begin
					push          = 1'b1;
					push_r.unterm = 1'b1;
					n_eos         = 1'b0;
				end
			endcase
		end
	end

	// Payload stores
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fq_q[0] <= in_byte;
		end else if (cmd.step) begin
			fq_q   <= n_fq;
			held_q <= n_held;
			em_q   <= n_em;
		end
		if (cmd.step && push) pend_q <= push_r;
		if ((cmd.step && push && pend_v_q) || (cmd.finish && pend_v_q)) out_q <= pend_q;
	end

	// Control and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= seud_pkg::MODE_TEXT;
			acc_q      <= '0;
			hs_q       <= '0;
			hn_q       <= '0;
			fq_n_q     <= '0;
			fq_p_q     <= '0;
			eos_q      <= 1'b0;
			em_n_q     <= '0;
			em_p_q     <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				fq_n_q <= in_eos ? 3'd0 : 3'd1;
				fq_p_q <= 3'd0;
				eos_q  <= in_eos;
			end else if (cmd.step) begin
				mode_q <= n_mode;
				acc_q  <= n_acc;
				hs_q   <= n_hs;
				hn_q   <= n_hn;
				fq_n_q <= n_fq_n;
				fq_p_q <= n_fq_p;
				eos_q  <= n_eos;
				em_n_q <= n_em_n;
				em_p_q <= n_em_p;
			end
			// pending result moves out once the next one or the end is known
			if ((cmd.step && push && pend_v_q) || (cmd.finish && pend_v_q)) begin
				out_v_q    <= 1'b1;
				out_last_q <= cmd.finish;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (cmd.step && push) pend_v_q <= 1'b1;
			else if (cmd.finish) pend_v_q <= 1'b0;
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

endmodule

// ===== sim/string_escape_utf8_decoder_test.sv =====
// Self-checking testbench for the string unescaper: drives source bytes, predicts the
// decoded UTF-8 results and compares every result the block returns.
// Depends on seud_pkg and string_escape_utf8_decoder.
`timescale 1ns / 1ps

module string_escape_utf8_decoder_test;

	// One expected or observed result
	typedef struct {
		bit [7:0] data;
		bit       valid;
		bit       done;
		bit       unterm;
		bit       last;
	} decoded_t;

	// Predicts decoded bytes from accepted requests and checks the results
	class unescape_scoreboard;
		bit [1:0]  mode;
		bit [15:0] acc;
		bit [2:0]  digits;
		bit [15:0] hi_surr;
		bit [7:0]  held[6];
		bit [2:0]  held_n;
		decoded_t  step_q[$];
		decoded_t  pending[$];
		int        errors;
		int        checked;

		function void put(bit [7:0] b, bit v, bit d, bit u);
			decoded_t r;
			r.data = b; r.valid = v; r.done = d; r.unterm = u; r.last = 0;
			if (step_q.size() < 10) step_q.push_back(r);
		endfunction

		function void emit(bit [7:0] b);
			put(b, 1, 0, 0);
		endfunction

		function int hexval(bit [7:0] b);
			if (b >= "0" && b <= "9") return b - "0";
			if (b >= "a" && b <= "f") return b - "a" + 10;
			if (b >= "A" && b <= "F") return b - "A" + 10;
			return -1;
		endfunction

		function void encode(int unsigned cp);
			if (cp < 'h80) begin
				emit(cp[7:0]);
			end else if (cp < 'h800) begin
				emit(8'hC0 | cp[10:6]);
				emit(8'h80 | cp[5:0]);
			end else if (cp <= 'hFFFF) begin
				emit(8'hE0 | cp[15:12]);
				emit(8'h80 | cp[11:6]);
				emit(8'h80 | cp[5:0]);
			end else begin
				emit(8'hF0 | cp[20:18]);
				emit(8'h80 | cp[17:12]);
				emit(8'h80 | cp[11:6]);
				emit(8'h80 | cp[5:0]);
			end
		endfunction

		function void clear();
			mode = seud_pkg::MODE_TEXT; acc = 0; digits = 0; hi_surr = 0; held_n = 0;
		endfunction

		// lone high surrogate goes out as is, then the held bytes are decoded again
		function void look_fail();
			bit [7:0] copy[6];
			int n;
			n = held_n;
			for (int i = 0; i < n; i++) copy[i] = held[i];
			encode(hi_surr);
			clear();
			for (int i = 0; i < n; i++) feed(copy[i]);
		endfunction

		function void feed(bit [7:0] b);
			int h;
			int idx;
			bit ok;
			int unsigned cp;
			h = hexval(b);
			case (mode)
				seud_pkg::MODE_ESC: begin
					mode = seud_pkg::MODE_TEXT;
					case (b)
						seud_pkg::CH_QUOTE, seud_pkg::CH_BSL, seud_pkg::CH_SLASH: emit(b);
						seud_pkg::CH_B: emit(seud_pkg::CH_BS);
						seud_pkg::CH_F: emit(seud_pkg::CH_FF);
						seud_pkg::CH_N: emit(seud_pkg::CH_LF);
						seud_pkg::CH_R: emit(seud_pkg::CH_CR);
						seud_pkg::CH_T: emit(seud_pkg::CH_TAB);
						seud_pkg::CH_E: emit(seud_pkg::CH_ESC);
						seud_pkg::CH_U: begin
							mode = seud_pkg::MODE_HEX; acc = 0; digits = 0; held_n = 0;
						end
						default: begin
							emit(seud_pkg::CH_BSL);
							emit(b);
						end
					endcase
				end
				seud_pkg::MODE_HEX: begin
					if (h < 0) begin
						emit(seud_pkg::CH_BSL);
						emit(seud_pkg::CH_U);
						for (int i = 0; i < held_n; i++) emit(held[i]);
						clear();
						feed(b);
					end else begin
						if (held_n < 6) begin
							held[held_n] = b;
							held_n++;
						end
						acc = {acc[11:0], h[3:0]};
						digits++;
						if (digits >= 4) begin
							cp = acc;
							clear();
							if (cp >= 'hD800 && cp <= 'hDBFF) begin
								hi_surr = cp[15:0];
								mode = seud_pkg::MODE_LOOK;
							end else begin
								encode(cp);
							end
						end
					end
				end
				seud_pkg::MODE_LOOK: begin
					idx = held_n;
					if (idx == 0) ok = (b == seud_pkg::CH_BSL);
					else if (idx == 1) ok = (b == seud_pkg::CH_U);
					else ok = (h >= 0 && idx < 6);
					if (!ok) begin
						look_fail();
						feed(b);
					end else begin
						if (idx >= 2) acc = {acc[11:0], h[3:0]};
						if (idx < 5) begin
							held[idx] = b;
							held_n++;
						end else if (acc >= 'hDC00 && acc <= 'hDFFF) begin
							cp = 'h10000 + ((int'(hi_surr) - 'hD800) << 10) + (int'(acc) - 'hDC00);
							clear();
							encode(cp);
						end else begin
							look_fail();
							feed(b);
						end
					end
				end
				default: begin
					if (b == seud_pkg::CH_QUOTE) begin
						clear();
						put(0, 0, 1, 0);
					end else if (b == seud_pkg::CH_LF) begin
						// newline dropped
					end else if (b == seud_pkg::CH_BSL) begin
						mode = seud_pkg::MODE_ESC;
					end else begin
						emit(b);
					end
				end
			endcase
		endfunction

		// end of source: pending escape goes out first
		function void flush();
			if (mode == seud_pkg::MODE_ESC) begin
				emit(seud_pkg::CH_BSL);
			end else if (mode == seud_pkg::MODE_HEX) begin
				emit(seud_pkg::CH_BSL);
				emit(seud_pkg::CH_U);
				for (int i = 0; i < held_n; i++) emit(held[i]);
			end else if (mode == seud_pkg::MODE_LOOK) begin
				look_fail();
				flush();
				return;
			end
			clear();
		endfunction

		function void note_request(bit [7:0] b, bit eos);
			step_q.delete();
			if (eos) begin
				flush();
				put(0, 0, 0, 1);
				clear();
			end else begin
				feed(b);
			end
			if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1;
			foreach (step_q[i]) pending.push_back(step_q[i]);
		endfunction

		function void check_result(bit [7:0] d, bit [2:0] u, bit l);
			decoded_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, got data=%h user=%b last=%b",
					$time, d, u, l);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d != e.data || u[0] != e.valid || u[1] != e.done || u[2] != e.unterm
					|| l != e.last) begin
				$display("%0t: mismatch, expected byte=%h valid=%b done=%b unterm=%b last=%b",
					$time, e.data, e.valid, e.done, e.unterm, e.last);
				$display("%0t:           actual   byte=%h valid=%b done=%b unterm=%b last=%b",
					$time, d, u[0], u[1], u[2], l);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	unescape_scoreboard sb;
	int  n_sent;
	int  n_strings;
	int  n_pairs;
	bit  quiet;
	bit  long_hold_done;

	string_escape_utf8_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Timeout
	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// One source request, with an occasional idle burst before it
	task automatic send_req(input bit [7:0] b, input bit eos);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= eos;
		do @(posedge clk); while (!s_tready);
		sb.note_request(b, eos);
		n_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_req(s[i], 1'b0);
	endtask

	// backslash, u and four hex digits in random case
	task automatic send_uesc(input bit [15:0] v);
		bit [7:0] c;
		bit [3:0] nib;
		send_req(seud_pkg::CH_BSL, 1'b0);
		send_req(seud_pkg::CH_U, 1'b0);
		for (int i = 3; i >= 0; i--) begin
			nib = v[i*4 +: 4];
			if (nib < 10) c = "0" + nib;
			else c = 8'(($urandom_range(0, 1) ? "a" : "A") + nib - 10);
			send_req(c, 1'b0);
		end
	endtask

	// Waits until every predicted result has come back
	task automatic drain_wait();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic send_rand_piece();
		bit [7:0] c;
		case ($urandom_range(0, 13))
			0, 1, 2: send_req(8'($urandom_range(0, 255)), 1'b0);
			3: begin
				c = 8'($urandom_range(32, 126));
				if (c == seud_pkg::CH_QUOTE || c == seud_pkg::CH_BSL) c = "x";
				send_req(c, 1'b0);
			end
			4: begin
				send_req(seud_pkg::CH_BSL, 1'b0);
				case ($urandom_range(0, 9))
					0: c = seud_pkg::CH_QUOTE; 1: c = seud_pkg::CH_BSL;
					2: c = seud_pkg::CH_SLASH; 3: c = seud_pkg::CH_B;
					4: c = seud_pkg::CH_F; 5: c = seud_pkg::CH_N; 6: c = seud_pkg::CH_R;
					7: c = seud_pkg::CH_T; 8: c = seud_pkg::CH_E;
					default: c = 8'($urandom_range(0, 255));
				endcase
				send_req(c, 1'b0);
			end
			5, 6: send_uesc(16'($urandom_range(0, 16'hFFFF)));
			7: send_uesc(16'($urandom_range(0, 16'h7FF)));
			8, 9: begin
				send_uesc(16'($urandom_range(16'hD800, 16'hDBFF)));
				send_uesc(16'($urandom_range(16'hDC00, 16'hDFFF)));
				n_pairs++;
			end
			10: begin
				// high surrogate with a broken or out-of-range follow-up
				send_uesc(16'($urandom_range(16'hD800, 16'hDBFF)));
				case ($urandom_range(0, 3))
					0: send_uesc(16'($urandom_range(0, 16'hFFFF)));
					1: send_req(seud_pkg::CH_BSL, 1'b0);
					2: begin
						send_req(seud_pkg::CH_BSL, 1'b0);
						send_req(seud_pkg::CH_U, 1'b0);
						send_req("d", 1'b0);
					end
					default: send_req(8'($urandom_range(0, 255)), 1'b0);
				endcase
			end
			11: begin
				// malformed \u: cut off after a few digits
				send_req(seud_pkg::CH_BSL, 1'b0);
				send_req(seud_pkg::CH_U, 1'b0);
				repeat ($urandom_range(0, 3)) send_req("7", 1'b0);
				send_req(8'($urandom_range(0, 255)), 1'b0);
			end
			12: send_req(seud_pkg::CH_LF, 1'b0);
			default: send_req(seud_pkg::CH_BSL, 1'b0);
		endcase
	endtask

	// Receiver: checks results and stalls in bursts, once for a long stretch
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!long_hold_done && n_sent >= 120) begin
				long_hold_done = 1;
				stall_left = 300;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin
		sb = new();
		sb.clear();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, escapes, \u forms, surrogate pair, malformed, end of source
		send_req(8'h00, 1'b0);
		send_req(8'hFF, 1'b0);
		send_req(seud_pkg::CH_LF, 1'b0);
		send_text("\\\"\\\\\\/\\b\\f\\n\\r\\t\\e\\q");
		send_uesc(16'h0041);
		send_uesc(16'h00E9);
		send_uesc(16'h20AC);
		send_uesc(16'hD83D);
		send_uesc(16'hDE00);
		send_text("\\u1G");
		send_req(seud_pkg::CH_QUOTE, 1'b0);
		send_uesc(16'hDBFF);
		send_req(8'hAA, 1'b1);
		send_text("\\u12");
		send_req(8'h55, 1'b1);

		// pause until everything directed has come back
		s_tvalid <= 1'b0;
		drain_wait();
		repeat (20) @(posedge clk);

		// random strings, each closed by a quote or by end of source
		while (n_sent < 262) begin
			if (n_sent > 210) quiet = 1;
			repeat ($urandom_range(1, 6)) send_rand_piece();
			if ($urandom_range(0, 5) == 0) send_req(8'($urandom_range(0, 255)), 1'b1);
			else send_req(seud_pkg::CH_QUOTE, 1'b0);
			n_strings++;
		end
		s_tvalid <= 1'b0;

		drain_wait();
		repeat (40) @(posedge clk);
		$display("Sent %0d source bytes in %0d random strings (%0d surrogate pairs),",
			n_sent, n_strings, n_pairs);
		$display("checked %0d results including a long output stall.", sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
